/* src/swm_pkg.sv */
// shared constants and types for the sliding window maximum filter
package swm_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int LEN_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd3;

  // per-transaction control broadcast along the cell chain
  typedef struct packed {
    logic clear;  // config write: drop every candidate
    logic step;   // input transaction accepted this cycle
    logic flush;  // sequence start: no old candidate survives
    logic shift;  // front candidate leaves the window, queue moves up one
  } ctrl_t;

endpackage

/* src/swm_cell.sv */
// one candidate slot of the monotonic queue chain
module swm_cell #(
  parameter int AGE_W = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swm_pkg::ctrl_t                       ctrl,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 prev_keep,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  right_value,
  input  logic        [AGE_W-1:0]              right_age,
  input  logic                                 right_keep,
  output logic                                 valid,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  value,
  output logic        [AGE_W-1:0]              age,
  output logic                                 keep
);

  logic                                src_keep;
  logic signed [swm_pkg::SAMPLE_W-1:0] src_value;
  logic        [AGE_W-1:0]             src_age;

  // survives the back-side pruning: strictly larger than the new sample
  assign keep = valid && !ctrl.flush && (value > sample);

  assign src_keep  = ctrl.shift ? right_keep  : keep;
  assign src_value = ctrl.shift ? right_value : value;
  assign src_age   = ctrl.shift ? right_age   : age;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.step) begin
      if (src_keep) begin
        valid <= 1'b1;
        value <= src_value;
        age   <= src_age + AGE_W'(1);
      end else if (prev_keep) begin
        // first slot after the surviving prefix takes the new sample
        valid <= 1'b1;
        value <= sample;
        age   <= '0;
      end else begin
        valid <= 1'b0;
      end
    end
  end

endmodule

/* src/swm_out_buf.sv */
// two-entry output register with skid slot
module swm_out_buf (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  push_data,
  output logic                                 ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  out_data
);

  logic                                skid_valid;
  logic signed [swm_pkg::SAMPLE_W-1:0] skid_data;
  logic                                pop;

  assign ready = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

/* src/sliding_window_maximum.sv */
// top level: streaming sliding window maximum over a chain of candidate cells
// a result is registered in the output register, or first in the skid slot while one waits
// throughput: one input transaction per cycle while in_ready is high; each updates the cell chain
// a two-entry output buffer keeps input open while one result waits downstream
// reset: window_len returns to 3, all cells empty, fill count zero, output buffer empty
// no clearing pass: reset and config writes take effect at the next edge
module sliding_window_maximum #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 seq_start,
  input  logic                                 window_len_we,
  input  logic        [swm_pkg::LEN_W-1:0]     window_len,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  window_max
);

  // candidate ages stay below the window, so they fit in log2(WINDOW_MAX) bits
  localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  // fill count saturates at WINDOW_MAX
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  // common width for window compares
  localparam int CMP_W = (CNT_W > swm_pkg::LEN_W) ? CNT_W : swm_pkg::LEN_W;

  logic [swm_pkg::LEN_W-1:0] win_len;
  logic [CNT_W-1:0]          fill_count;
  logic [CNT_W-1:0]          fill_base;
  logic [CNT_W-1:0]          fill_next;
  logic [CMP_W-1:0]          len_ext;
  logic [CMP_W-1:0]          w_eff;
  logic [CMP_W-1:0]          front_age_inc;
  logic                      accept;
  logic                      expire;
  logic                      emit;
  logic                      buf_ready;
  swm_pkg::ctrl_t            ctrl;

  // cell state, one extra slot past the end tied off as empty
  logic                                c_valid [0:WINDOW_MAX];
  logic                                c_keep  [0:WINDOW_MAX];
  logic signed [swm_pkg::SAMPLE_W-1:0] c_value [0:WINDOW_MAX];
  logic        [AGE_W-1:0]             c_age   [0:WINDOW_MAX];

  logic                                res_keep;
  logic signed [swm_pkg::SAMPLE_W-1:0] res_value;
  logic signed [swm_pkg::SAMPLE_W-1:0] res_data;

  assign in_ready = buf_ready;
  assign accept   = in_valid && in_ready;

  // effective window: zero acts as one, large values clamp to the chain length
  assign len_ext = CMP_W'(win_len);
  always_comb begin
    if (len_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (len_ext > CMP_W'(WINDOW_MAX)) begin
      w_eff = CMP_W'(WINDOW_MAX);
    end else begin
      w_eff = len_ext;
    end
  end

  // ages are distinct and decrease toward the back, so only the front can expire
  assign front_age_inc = CMP_W'(c_age[0]) + CMP_W'(1);
  assign expire        = c_valid[0] && !seq_start && (front_age_inc >= w_eff);

  assign ctrl.clear = window_len_we;
  assign ctrl.step  = accept;
  assign ctrl.flush = seq_start;
  assign ctrl.shift = expire;

  // end of chain: nothing to pull in
  assign c_valid[WINDOW_MAX] = 1'b0;
  assign c_keep[WINDOW_MAX]  = 1'b0;
  assign c_value[WINDOW_MAX] = '0;
  assign c_age[WINDOW_MAX]   = '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic prev_keep;

    if (i == 0) begin : g_front
      // the front slot always holds something after a step
      assign prev_keep = 1'b1;
    end else begin : g_body
      // slot ahead of this cell's source, after the optional shift
      assign prev_keep = expire ? c_keep[i] : c_keep[i-1];
    end

    swm_cell #(
      .AGE_W (AGE_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .sample      (sample),
      .prev_keep   (prev_keep),
      .right_value (c_value[i+1]),
      .right_age   (c_age[i+1]),
      .right_keep  (c_keep[i+1]),
      .valid       (c_valid[i]),
      .value       (c_value[i]),
      .age         (c_age[i]),
      .keep        (c_keep[i])
    );
  end

  // result is the new front: surviving old front, else the new sample
  assign res_keep  = expire ? c_keep[1]  : c_keep[0];
  assign res_value = expire ? c_value[1] : c_value[0];
  assign res_data  = res_keep ? res_value : sample;

  // warm-up count, restarted by a sequence start
  assign fill_base = seq_start ? '0 : fill_count;
  assign fill_next = (fill_base == CNT_W'(WINDOW_MAX)) ? fill_base : fill_base + CNT_W'(1);
  assign emit      = CMP_W'(fill_next) >= w_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len    <= swm_pkg::LEN_RESET;
      fill_count <= '0;
    end else if (window_len_we) begin
      // a new window length starts a new sequence
      win_len    <= window_len;
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_next;
    end
  end

  swm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && emit),
    .push_data (res_data),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (window_max)
  );

endmodule

/* src/swm_checker.sv */
// port-level checks for the sliding window maximum filter, bound to the top level
module swm_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [swm_pkg::SAMPLE_W-1:0]  window_max
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_max))
    else $error("stalled result changed");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a result only appears after an input transaction
  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input transaction");

  // after input stalls, it stays stalled while the waiting results are still blocked
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    !in_ready && !out_ready |=> !in_ready)
    else $error("input reopened while results were still blocked");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .window_max (window_max)
);
